@@ sv/kfpv_pkg.sv @@
package kfpv_pkg;

	// default number of fraction bits of the fixed-point format
	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [0:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [0:0] REG_MEASURE_NOISE = 1'b1;

	// input item kinds
	localparam logic CMD_INIT    = 1'b0;
	localparam logic CMD_MEASURE = 1'b1;

	// sequencer states
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PRED  = 9'b000000010,
		ST_SUMS  = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_ACC   = 9'b000010000,
		ST_CHECK = 9'b000100000,
		ST_DIVLD = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} kfpv_state_t;

	// sign extend a 32-bit value to the accumulator width
	function automatic logic signed [65:0] sx32(input logic [31:0] v);
		sx32 = {{34{v[31]}}, v};
	endfunction

	// sign extend a 64-bit value to the accumulator width
	function automatic logic signed [65:0] sx64(input logic [63:0] v);
		sx64 = {{2{v[63]}}, v};
	endfunction

	// clamp a wide signed value into 32 bits
	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			sat32 = 32'h7fff_ffff;
		end else if (v < -66'sd2147483648) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

@@ sv/kalman_filter_position_velocity_top.sv @@
// Two-state constant-velocity Kalman filter (position, velocity) in signed fixed point with
// FRAC_BITS fraction bits. An init item (tuser = 0) loads the state and resets the covariance
// to identity. A measurement item (tuser = 1) runs predict and update: multiply-accumulate for
// the determinant and the four gain numerators, four gain divisions on one shared restoring
// divider (one quotient bit per cycle; a gain that overflows is saturated without dividing),
// and multiply-accumulate for the state and covariance update, all through one shared 32x32
// multiplier. One item is in work at a time; the result sits in an output register, so the
// next item is taken while it waits.
// A zero innovation determinant skips the update and sets the singular flag.
module kalman_filter_position_velocity_top #(
	parameter int FRAC_BITS = kfpv_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_in [31:0], vel_in [63:32]
	input  logic [0:0]  s_tuser,   // cmd [0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // est_pos [31:0], est_vel [63:32]
	output logic [0:0]  m_tuser,   // singular [0]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import kfpv_pkg::*;

	localparam logic [31:0] ONE        = 32'(1) << FRAC_BITS;
	localparam logic [30:0] NOISE_RST  = 31'(1) << FRAC_BITS;
	localparam int          NW         = 65 + FRAC_BITS;
	localparam logic [4:0]  STEP_GAIN  = 5'd9;
	localparam logic [4:0]  STEP_UPD   = 5'd10;
	localparam logic [4:0]  STEP_LAST  = 5'd21;
	localparam logic [4:0]  STEP_SUB   = 5'd14;
	localparam logic [4:0]  DIV_LAST   = 5'd30;
	localparam logic [1:0]  GAIN_LAST  = 2'd3;

	kfpv_state_t state_q;

	// architectural state and control
	logic [30:0] q_noise_q, r_noise_q;
	logic [31:0] pos_q, vel_q, cov0_q, cov1_q, cov2_q, cov3_q;
	logic        mvalid_q;
	logic [4:0]  step_q;
	logic [1:0]  gidx_q;
	logic [4:0]  cnt_q;
	logic        sing_q;

	// datapath registers
	logic [31:0] zp_q, zv_q;
	logic [31:0] x0_q, x1_q, p00_q, p01_q, p10_q, p11_q, s00_q, s11_q, y0_q, y1_q;
	logic [31:0] k00_q, k01_q, k10_q, k11_q;
	logic [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic [64:0] det_q, n00_q, n01_q, n10_q, n11_q;
	logic [64:0] dmag_q, rem_q;
	logic [30:0] low_q, quo_q;
	logic        neg_q;
	logic [31:0] opos_q, ovel_q;
	logic        osing_q;

	logic        in_fire, out_free;
	logic [31:0] opa, opb, base;
	logic signed [65:0] prod_x, scaled, term, acc_next;
	logic [64:0] num, nmag, dmag, hi_x;
	logic [NW-1:0] big;
	logic        ovf, ge;
	logic [65:0] rem2;
	logic [30:0] qn;
	logic [31:0] kval, kdiv;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !mvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mvalid_q;
	assign m_tdata   = {ovel_q, opos_q};
	assign m_tuser   = osing_q;

	// operand selection for the shared multiplier
	always_comb begin
		opa  = '0;
		opb  = '0;
		base = '0;
		case (step_q)
			5'd0:  begin opa = s00_q; opb = s11_q; end
			5'd1:  begin opa = p01_q; opb = p10_q; end
			5'd2:  begin opa = p00_q; opb = s11_q; end
			5'd3:  begin opa = p01_q; opb = p10_q; end
			5'd4:  begin opa = p01_q; opb = s00_q; end
			5'd5:  begin opa = p00_q; opb = p01_q; end
			5'd6:  begin opa = p10_q; opb = s11_q; end
			5'd7:  begin opa = p11_q; opb = p10_q; end
			5'd8:  begin opa = p11_q; opb = s00_q; end
			5'd9:  begin opa = p10_q; opb = p01_q; end
			5'd10: begin opa = k00_q; opb = y0_q; base = x0_q; end
			5'd11: begin opa = k01_q; opb = y1_q; end
			5'd12: begin opa = k10_q; opb = y0_q; base = x1_q; end
			5'd13: begin opa = k11_q; opb = y1_q; end
			5'd14: begin opa = k00_q; opb = p00_q; base = p00_q; end
			5'd15: begin opa = k01_q; opb = p10_q; end
			5'd16: begin opa = k00_q; opb = p01_q; base = p01_q; end
			5'd17: begin opa = k01_q; opb = p11_q; end
			5'd18: begin opa = k10_q; opb = p00_q; base = p10_q; end
			5'd19: begin opa = k11_q; opb = p10_q; end
			5'd20: begin opa = k10_q; opb = p01_q; base = p11_q; end
			5'd21: begin opa = k11_q; opb = p11_q; end
			default: begin opa = '0; opb = '0; base = '0; end
		endcase
	end

	// accumulate: exact differences for the gain terms, floored products for the update
	always_comb begin
		prod_x = sx64(prod_q);
		scaled = sx64(64'($signed(prod_q) >>> FRAC_BITS));
		term   = (step_q >= STEP_SUB) ? -scaled : scaled;
		if (step_q < STEP_UPD) begin
			acc_next = step_q[0] ? (acc_q - prod_x) : prod_x;
		end else begin
			acc_next = step_q[0] ? (acc_q + term) : (sx32(base) + term);
		end
	end

	// divider operand setup
	always_comb begin
		case (gidx_q)
			2'd0:    num = n00_q;
			2'd1:    num = n01_q;
			2'd2:    num = n10_q;
			default: num = n11_q;
		endcase
		nmag = num[64] ? (65'd0 - num) : num;
		dmag = det_q[64] ? (65'd0 - det_q) : det_q;
		big  = {nmag, {FRAC_BITS{1'b0}}};
		hi_x = 65'(big[NW-1:31]);
		ovf  = hi_x >= dmag_q;
		rem2 = {rem_q, low_q[30]};
		ge   = rem2 >= {1'b0, dmag_q};
		qn   = {quo_q[29:0], ge};
		kdiv = neg_q ? (32'd0 - {1'b0, qn}) : {1'b0, qn};
		kval = (num[64] ^ det_q[64]) ? 32'h8000_0000 : 32'h7fff_ffff;
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			q_noise_q <= NOISE_RST;
			r_noise_q <= NOISE_RST;
			pos_q     <= '0;
			vel_q     <= '0;
			cov0_q    <= ONE;
			cov1_q    <= '0;
			cov2_q    <= '0;
			cov3_q    <= ONE;
			mvalid_q  <= 1'b0;
			step_q    <= '0;
			gidx_q    <= '0;
			cnt_q     <= '0;
			sing_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_PROCESS_NOISE: q_noise_q <= cfg_data;
					REG_MEASURE_NOISE: r_noise_q <= cfg_data;
					default: ;
				endcase
			end
			// result valid: set when a result is loaded, cleared when it is taken
			if (state_q == ST_DONE && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser[0] == CMD_INIT) begin
							pos_q   <= s_tdata[31:0];
							vel_q   <= s_tdata[63:32];
							cov0_q  <= ONE;
							cov1_q  <= '0;
							cov2_q  <= '0;
							cov3_q  <= ONE;
							sing_q  <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_PRED;
						end
					end
				end
				ST_PRED: state_q <= ST_SUMS;
				ST_SUMS: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					case (step_q)
						5'd11: pos_q  <= sat32(acc_next);
						5'd13: vel_q  <= sat32(acc_next);
						5'd15: cov0_q <= sat32(acc_next);
						5'd17: cov1_q <= sat32(acc_next);
						5'd19: cov2_q <= sat32(acc_next);
						5'd21: cov3_q <= sat32(acc_next);
						default: ;
					endcase
					if (step_q == STEP_GAIN) begin
						state_q <= ST_CHECK;
					end else if (step_q == STEP_LAST) begin
						sing_q  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						step_q  <= step_q + 5'd1;
						state_q <= ST_MUL;
					end
				end
				ST_CHECK: begin
					if (det_q == '0) begin
						pos_q   <= x0_q;
						vel_q   <= x1_q;
						cov0_q  <= p00_q;
						cov1_q  <= p01_q;
						cov2_q  <= p10_q;
						cov3_q  <= p11_q;
						sing_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						gidx_q  <= '0;
						state_q <= ST_DIVLD;
					end
				end
				ST_DIVLD: begin
					cnt_q <= '0;
					if (!ovf) begin
						state_q <= ST_DIV;
					end else if (gidx_q == GAIN_LAST) begin
						step_q  <= STEP_UPD;
						state_q <= ST_MUL;
					end else begin
						gidx_q <= gidx_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						if (gidx_q == GAIN_LAST) begin
							step_q  <= STEP_UPD;
							state_q <= ST_MUL;
						end else begin
							gidx_q  <= gidx_q + 2'd1;
							state_q <= ST_DIVLD;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				zp_q <= s_tdata[31:0];
				zv_q <= s_tdata[63:32];
			end
			// predict: x = F x, P = F P F' + Q I
			ST_PRED: begin
				x0_q  <= sat32(sx32(pos_q) + sx32(vel_q));
				x1_q  <= vel_q;
				p00_q <= sat32(sx32(cov0_q) + sx32(cov1_q) + sx32(cov2_q) + sx32(cov3_q)
					+ 66'(q_noise_q));
				p01_q <= sat32(sx32(cov1_q) + sx32(cov3_q));
				p10_q <= sat32(sx32(cov2_q) + sx32(cov3_q));
				p11_q <= sat32(sx32(cov3_q) + 66'(q_noise_q));
			end
			// innovation covariance diagonal and innovation
			ST_SUMS: begin
				s00_q <= sat32(sx32(p00_q) + 66'(r_noise_q));
				s11_q <= sat32(sx32(p11_q) + 66'(r_noise_q));
				y0_q  <= sat32(sx32(zp_q) - sx32(x0_q));
				y1_q  <= sat32(sx32(zv_q) - sx32(x1_q));
			end
			ST_MUL: prod_q <= 64'($signed(opa) * $signed(opb));
			ST_ACC: begin
				acc_q <= acc_next;
				case (step_q)
					5'd1: det_q <= acc_next[64:0];
					5'd3: n00_q <= acc_next[64:0];
					5'd5: n01_q <= acc_next[64:0];
					5'd7: n10_q <= acc_next[64:0];
					5'd9: n11_q <= acc_next[64:0];
					default: ;
				endcase
			end
			ST_CHECK: dmag_q <= dmag;
			// gain setup: saturate at once or seed the remainder
			ST_DIVLD: begin
				neg_q <= num[64] ^ det_q[64];
				rem_q <= hi_x;
				low_q <= big[30:0];
				quo_q <= '0;
				if (ovf) begin
					case (gidx_q)
						2'd0:    k00_q <= kval;
						2'd1:    k01_q <= kval;
						2'd2:    k10_q <= kval;
						default: k11_q <= kval;
					endcase
				end
			end
			// one quotient bit per cycle
			ST_DIV: begin
				rem_q <= ge ? 65'(rem2 - {1'b0, dmag_q}) : rem2[64:0];
				low_q <= {low_q[29:0], 1'b0};
				quo_q <= qn;
				if (cnt_q == DIV_LAST) begin
					case (gidx_q)
						2'd0:    k00_q <= kdiv;
						2'd1:    k01_q <= kdiv;
						2'd2:    k10_q <= kdiv;
						default: k11_q <= kdiv;
					endcase
				end
			end
			ST_DONE: begin
				if (out_free) begin
					opos_q  <= pos_q;
					ovel_q  <= vel_q;
					osing_q <= sing_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ tb/testbench.sv @@
module testbench;
	import kfpv_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int N_RANDOM = 1800;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [30:0] cfg_data;

	kalman_filter_position_velocity_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] vel;
		logic        singular;
	} estimate_t;

	typedef struct {
		logic        cmd;
		logic [31:0] pos;
		logic [31:0] vel;
		logic        check;
		estimate_t   want;
	} stim_row_t;

	// filter state mirrored by the predictor
	logic [30:0]        q_noise, r_noise;
	logic signed [31:0] xs [2];
	logic signed [31:0] pc [4];

	estimate_t   estimate_q [$];
	int          errors;
	int          send_idle, recv_idle;
	bit          hold_recv;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#400000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	function automatic logic signed [31:0] clamp(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// product shifted down, rounded toward minus infinity
	function automatic logic signed [127:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		return p >>> FB;
	endfunction

	// gain: (num << FB) / den toward zero, saturated
	function automatic logic signed [31:0] gain_div(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic        neg;
		logic [127:0] n, d, qv, rv;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		qv = n / d;
		rv = n % d;
		if (qv > 128'h1_0000_0000) qv = 128'h1_0000_0000;
		qv = (qv << FB) | (((rv << FB) / d) & ((128'd1 << FB) - 1));
		if (neg) begin
			if (qv >= 128'h8000_0000) return 32'sh80000000;
			return -$signed(qv[31:0]);
		end
		if (qv > 128'h7fff_ffff) return 32'sh7fffffff;
		return qv[31:0];
	endfunction

	function automatic void filter_reset();
		q_noise = 31'(1 << FB);
		r_noise = 31'(1 << FB);
		xs[0] = 0; xs[1] = 0;
		pc[0] = 1 << FB; pc[1] = 0; pc[2] = 0; pc[3] = 1 << FB;
	endfunction

	function automatic estimate_t filter_step(input logic cmd, input logic signed [31:0] zp,
			input logic signed [31:0] zv);
		logic signed [127:0] q, r, det;
		logic signed [31:0] x0, x1, p00, p01, p10, p11, s00, s11, k00, k01, k10, k11, y0, y1;
		estimate_t e;
		e.singular = 1'b0;
		if (cmd == CMD_INIT) begin
			xs[0] = zp; xs[1] = zv;
			pc[0] = 1 << FB; pc[1] = 0; pc[2] = 0; pc[3] = 1 << FB;
		end else begin
			q = q_noise;
			r = r_noise;
			x0 = clamp(128'(xs[0]) + xs[1]);
			x1 = xs[1];
			p00 = clamp(128'(pc[0]) + pc[1] + pc[2] + pc[3] + q);
			p01 = clamp(128'(pc[1]) + pc[3]);
			p10 = clamp(128'(pc[2]) + pc[3]);
			p11 = clamp(128'(pc[3]) + q);
			s00 = clamp(128'(p00) + r);
			s11 = clamp(128'(p11) + r);
			det = 128'(s00) * s11 - 128'(p01) * p10;
			if (det == 0) begin
				e.singular = 1'b1;
				xs[0] = x0; xs[1] = x1;
				pc[0] = p00; pc[1] = p01; pc[2] = p10; pc[3] = p11;
			end else begin
				k00 = gain_div(128'(p00) * s11 - 128'(p01) * p10, det);
				k01 = gain_div(128'(p01) * s00 - 128'(p00) * p01, det);
				k10 = gain_div(128'(p10) * s11 - 128'(p11) * p10, det);
				k11 = gain_div(128'(p11) * s00 - 128'(p10) * p01, det);
				y0 = clamp(128'(zp) - x0);
				y1 = clamp(128'(zv) - x1);
				xs[0] = clamp(128'(x0) + fmul(k00, y0) + fmul(k01, y1));
				xs[1] = clamp(128'(x1) + fmul(k10, y0) + fmul(k11, y1));
				pc[0] = clamp(128'(p00) - fmul(k00, p00) - fmul(k01, p10));
				pc[1] = clamp(128'(p01) - fmul(k00, p01) - fmul(k01, p11));
				pc[2] = clamp(128'(p10) - fmul(k10, p00) - fmul(k11, p10));
				pc[3] = clamp(128'(p11) - fmul(k10, p01) - fmul(k11, p11));
			end
		end
		e.pos = xs[0];
		e.vel = xs[1];
		return e;
	endfunction

	task automatic idle_cycles(input int pct);
		while ($urandom_range(99, 0) < pct) @(negedge clk);
	endtask

	// offer one input item and record its expected estimate
	task automatic send_item(input logic cmd, input logic [31:0] pos, input logic [31:0] vel,
			input logic check, input estimate_t want);
		estimate_t e;
		idle_cycles(send_idle);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {vel, pos};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		e = filter_step(cmd, pos, vel);
		if (check && e != want) begin
			report("directed row", {e.pos[30:0], e.singular}, {want.pos[30:0], want.singular});
		end
		estimate_q = {estimate_q, e};
		@(negedge clk);
		s_tvalid <= 1'b0;
		// the block is busy for at least this cycle after taking an item
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [30:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_PROCESS_NOISE) q_noise = val;
		else r_noise = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (estimate_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5, 0))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(200000, 0) - 100000;
			3: return $urandom_range(2000000000, 0) - 1000000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_noise();
		case ($urandom_range(3, 0))
			0: return 31'h7fff_ffff;
			1: return 31'd0;
			2: return 31'($urandom_range(1 << 20, 0));
			default: return 31'($urandom);
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_recv) m_tready <= 1'b0;
			else m_tready <= ($urandom_range(99, 0) >= recv_idle);
		end
	end

	// compare each result with the oldest expected estimate
	always @(posedge clk) begin
		estimate_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (estimate_q.size() == 0) begin
				report("unexpected result", m_tdata[31:0], 32'h0);
			end else begin
				w = estimate_q.pop_front();
				if (m_tdata[31:0] !== w.pos) report("est_pos", m_tdata[31:0], w.pos);
				if (m_tdata[63:32] !== w.vel) report("est_vel", m_tdata[63:32], w.vel);
				if (m_tuser[0] !== w.singular) begin
					report("singular", 32'(m_tuser), 32'(w.singular));
				end
			end
		end
	end

	stim_row_t rows [$];

	function automatic stim_row_t row(input logic cmd, input logic [31:0] pos,
			input logic [31:0] vel, input logic check, input logic [31:0] wp,
			input logic [31:0] wv, input logic ws);
		stim_row_t t;
		t.cmd = cmd; t.pos = pos; t.vel = vel; t.check = check;
		t.want.pos = wp; t.want.vel = wv; t.want.singular = ws;
		return t;
	endfunction

	initial begin
		int phase;
		errors = 0;
		hold_recv = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_INIT;
		cfg_valid = 1'b0;
		cfg_index = REG_PROCESS_NOISE;
		cfg_data = '0;
		filter_reset();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part: extremes and both commands
		rows = {rows, row(CMD_MEASURE, 0, 0, 1'b0, 0, 0, 1'b0)};
		rows = {rows, row(CMD_INIT, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
			32'h7fff_ffff, 32'h8000_0000, 1'b0)};
		rows = {rows, row(CMD_MEASURE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 0, 0, 1'b0)};
		rows = {rows, row(CMD_INIT, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
			32'h8000_0000, 32'h7fff_ffff, 1'b0)};
		rows = {rows, row(CMD_MEASURE, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 0, 0, 1'b0)};
		rows = {rows, row(CMD_MEASURE, 32'hffff_ffff, 32'h0001_0000, 1'b0, 0, 0, 1'b0)};
		rows = {rows, row(CMD_INIT, 32'h0001_0000, 32'h0000_8000, 1'b1,
			32'h0001_0000, 32'h0000_8000, 1'b0)};
		rows = {rows, row(CMD_MEASURE, 32'h0003_0000, 32'h0000_8000, 1'b0, 0, 0, 1'b0)};
		rows = {rows, row(CMD_MEASURE, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 0, 0, 1'b0)};
		foreach (rows[i]) send_item(rows[i].cmd, rows[i].pos, rows[i].vel, rows[i].check,
			rows[i].want);
		drain();

		// zero noise on a fresh identity-less covariance cannot be singular; zero P needs
		// a run of updates with zero noise, so drive Q and R to zero and measure repeatedly
		write_reg(REG_PROCESS_NOISE, 31'd0);
		write_reg(REG_MEASURE_NOISE, 31'd0);
		for (int i = 0; i < 6; i++) begin
			send_item(CMD_MEASURE, rand_value(), rand_value(), 1'b0, '0);
		end
		drain();
		write_reg(REG_PROCESS_NOISE, 31'h7fff_ffff);
		write_reg(REG_MEASURE_NOISE, 31'h7fff_ffff);
		for (int i = 0; i < 4; i++) begin
			send_item(CMD_MEASURE, rand_value(), rand_value(), 1'b0, '0);
		end

		// long receiver hold-off while items keep coming
		hold_recv = 1'b1;
		fork
			begin
				repeat (2000) @(negedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 5; i++) begin
				send_item(CMD_MEASURE, rand_value(), rand_value(), 1'b0, '0);
			end
		join
		drain();

		// random part in three idling phases, noise changed between chunks
		for (phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 36 : (phase == 1 ? 68 : 0);
			recv_idle = phase == 0 ? 68 : (phase == 1 ? 36 : 0);
			for (int chunk = 0; chunk < 4; chunk++) begin
				drain();
				write_reg(REG_PROCESS_NOISE, rand_noise());
				write_reg(REG_MEASURE_NOISE, rand_noise());
				for (int i = 0; i < N_RANDOM / 12; i++) begin
					if ($urandom_range(9, 0) == 0)
						send_item(CMD_INIT, rand_value(), rand_value(), 1'b0, '0);
					else
						send_item(CMD_MEASURE, rand_value(), rand_value(), 1'b0, '0);
				end
			end
		end
		drain();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
